// ===== rtl/sstf_pkg.sv =====
`default_nettype none

package sstf_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TRACK_W         = 16;
    localparam int TAG_W           = 8;
    localparam int PEND_W          = 5;
    localparam int HEAD_W          = TRACK_W + 1;
    localparam int DIST_W          = TRACK_W + 1;
    localparam int ENTRY_W         = TRACK_W + TAG_W;

    localparam logic REQ_ENQUEUE = 1'b0;
    localparam logic REQ_SERVICE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/sstf_ram.sv =====
`default_nettype none

module sstf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/sstf_dist.sv =====
`default_nettype none

module sstf_dist (
    input  wire logic signed [sstf_pkg::HEAD_W-1:0]  i_head,
    input  wire logic        [sstf_pkg::TRACK_W-1:0] i_track,
    output logic             [sstf_pkg::DIST_W-1:0]  o_dist
);

    import sstf_pkg::*;

    logic signed [HEAD_W:0] w_diff;
    logic signed [HEAD_W:0] w_abs;

    // The head is one bit wider than a track so that minus one is exact.
    assign w_diff = {i_head[HEAD_W-1], i_head} - $signed({2'b00, i_track});
    assign w_abs  = w_diff[HEAD_W] ? -w_diff : w_diff;
    assign o_dist = w_abs[DIST_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/sstf_request_scheduler.sv =====
`default_nettype none

// Channel   Direction  Handshake                Payload
// request   in         i_in_valid / o_in_stall  i_req_type, i_track, i_tag
// result    out        o_out_valid / i_out_stall o_ok, o_served_track, o_served_tag, o_pending
//
// Enqueues and failed services go straight to the finish state, which loads the result. A
// service with pending requests scans them through the single read port and the shared
// distance unit, then moves any later entries down by one in the shift state, and the
// finish state loads the result once the output register is free or being emptied.
// The table RAM needs no clearing pass; reset clears the count, the state and the valid flags and sets the head to -1.
// The next request is taken while a finished result still waits on a stalled output.

module sstf_request_scheduler #(
    parameter int QUEUE_DEPTH = sstf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_req_type,
    input  wire logic [sstf_pkg::TRACK_W-1:0]  i_track,
    input  wire logic [sstf_pkg::TAG_W-1:0]    i_tag,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_ok,
    output logic      [sstf_pkg::TRACK_W-1:0]  o_served_track,
    output logic      [sstf_pkg::TAG_W-1:0]    o_served_tag,
    output logic      [sstf_pkg::PEND_W-1:0]   o_pending
);

    import sstf_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic signed [HEAD_W-1:0] r_head, n_head;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_dptr, n_dptr;
    logic r_dvalid, n_dvalid;
    logic [CW-1:0] r_best_idx, n_best_idx;
    logic [DIST_W-1:0] r_best_d, n_best_d;
    logic [TRACK_W-1:0] r_best_trk, n_best_trk;
    logic [TAG_W-1:0] r_best_tag, n_best_tag;
    logic r_res_ok, n_res_ok;
    logic r_out_valid, n_out_valid;
    logic r_out_ok, n_out_ok;
    logic [TRACK_W-1:0] r_out_trk, n_out_trk;
    logic [TAG_W-1:0] r_out_tag, n_out_tag;
    logic [PEND_W-1:0] r_out_pend, n_out_pend;

    logic ram_we;
    logic [AW-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [CW-1:0] w_last;
    logic [CW-1:0] w_dprev;
    logic [DIST_W-1:0] w_dist;
    logic w_better;
    logic w_in_xfer;
    logic [CW+PEND_W-1:0] w_count_ext;

    sstf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sstf_dist u_dist (
        .i_head  (r_head),
        .i_track (ram_rdata[TRACK_W-1:0]),
        .o_dist  (w_dist)
    );

    assign w_last    = r_count - 1'b1;
    assign w_dprev   = r_dptr - 1'b1;
    assign ram_raddr = r_ptr[AW-1:0];
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_xfer = i_in_valid && !o_in_stall;
    assign w_count_ext = {{PEND_W{1'b0}}, n_count};

    // The newest entry also wins a tie; earlier entries must be strictly nearer.
    assign w_better = (r_dptr == w_last) ? (w_dist <= r_best_d) : (w_dist < r_best_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_head      <= '1;
            r_dvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_dvalid    <= n_dvalid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_dptr     <= n_dptr;
        r_best_idx <= n_best_idx;
        r_best_d   <= n_best_d;
        r_best_trk <= n_best_trk;
        r_best_tag <= n_best_tag;
        r_res_ok   <= n_res_ok;
        r_out_ok   <= n_out_ok;
        r_out_trk  <= n_out_trk;
        r_out_tag  <= n_out_tag;
        r_out_pend <= n_out_pend;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_ptr       = r_ptr;
        n_dptr      = r_dptr;
        n_dvalid    = r_dvalid;
        n_best_idx  = r_best_idx;
        n_best_d    = r_best_d;
        n_best_trk  = r_best_trk;
        n_best_tag  = r_best_tag;
        n_res_ok    = r_res_ok;
        n_out_valid = r_out_valid;
        n_out_ok    = r_out_ok;
        n_out_trk   = r_out_trk;
        n_out_tag   = r_out_tag;
        n_out_pend  = r_out_pend;
        ram_we      = 1'b0;
        ram_waddr   = r_count[AW-1:0];
        ram_wdata   = {i_tag, i_track};

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_best_trk = '0;
                    n_best_tag = '0;
                    n_res_ok   = 1'b0;
                    n_state    = ST_FINISH;
                    if (i_req_type == REQ_ENQUEUE) begin
                        if (r_count < DEPTH_C) begin
                            ram_we   = 1'b1;
                            n_count  = r_count + 1'b1;
                            n_res_ok = 1'b1;
                        end
                    end else if (r_count != '0) begin
                        n_ptr    = '0;
                        n_dvalid = 1'b0;
                        n_best_d = '1;
                        n_state  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_dvalid && w_better) begin
                    n_best_idx = r_dptr;
                    n_best_d   = w_dist;
                    n_best_trk = ram_rdata[TRACK_W-1:0];
                    n_best_tag = ram_rdata[ENTRY_W-1:TRACK_W];
                end
                if (r_dvalid && (r_dptr == w_last)) begin
                    n_ptr    = n_best_idx + 1'b1;
                    n_dvalid = 1'b0;
                    n_state  = ST_SHIFT;
                end else if (r_ptr <= w_last) begin
                    n_dvalid = 1'b1;
                    n_dptr   = r_ptr;
                    n_ptr    = r_ptr + 1'b1;
                end else begin
                    n_dvalid = 1'b0;
                end
            end
            ST_SHIFT: begin
                // Entries after the chosen one move down by one, keeping arrival order.
                if (r_dvalid) begin
                    ram_we    = 1'b1;
                    ram_waddr = w_dprev[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                if (r_ptr <= w_last) begin
                    n_dvalid = 1'b1;
                    n_dptr   = r_ptr;
                    n_ptr    = r_ptr + 1'b1;
                end else begin
                    n_dvalid = 1'b0;
                    if (!r_dvalid) begin
                        n_count  = w_last;
                        n_head   = $signed({1'b0, r_best_trk});
                        n_res_ok = 1'b1;
                        n_state  = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_trk   = r_best_trk;
                    n_out_tag   = r_best_tag;
                    n_out_pend  = w_count_ext[PEND_W-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_ok           = r_out_ok;
    assign o_served_track = r_out_trk;
    assign o_served_tag   = r_out_tag;
    assign o_pending      = r_out_pend;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("pending count exceeds table depth");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_SHIFT) |-> (r_count != '0))
        else $error("scan or shift running on an empty table");

    a_best_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT) |-> (r_best_idx < r_count))
        else $error("chosen entry lies outside the pending range");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |-> (r_out_trk == '0 && r_out_tag == '0))
        else $error("failed result carries a nonzero track or tag");

    a_service_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT && n_state == ST_FINISH) |=> (r_count == $past(r_count) - 1'b1))
        else $error("service did not remove exactly one entry");

endmodule

`default_nettype wire
